@@ hdl/fwop_pkg.sv @@
// ----------------------------------------------------------------------------
// fwop_pkg
// Shared sizes, command, policy and status codes, and the result record of
// the FIFO with overflow policy.
// ----------------------------------------------------------------------------
package fwop_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int WORD_BITS   = 64;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CMD_W      = 2;
  localparam int DATA_W     = 64;
  localparam int STAT_W     = 3;
  localparam int FILL_W     = 5;
  localparam int CTR_W      = 32;
  localparam int CAP_W      = 5;
  localparam int POL_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam int OUT_FIELDS_W = DATA_W + FILL_W + 2 + 3 * CTR_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;

  localparam logic [POL_W-1:0] POL_DROP_NEW = 2'd0;
  localparam logic [POL_W-1:0] POL_DROP_OLD = 2'd1;
  localparam logic [POL_W-1:0] POL_BLOCK    = 2'd2;

  localparam logic [STAT_W-1:0] ST_ACCEPTED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEW_DROPPED = 3'd1;
  localparam logic [STAT_W-1:0] ST_OLD_DROPPED = 3'd2;
  localparam logic [STAT_W-1:0] ST_RETRY       = 3'd3;
  localparam logic [STAT_W-1:0] ST_REFUSED     = 3'd4;
  localparam logic [STAT_W-1:0] ST_POPPED      = 3'd5;
  localparam logic [STAT_W-1:0] ST_EMPTY       = 3'd6;
  localparam logic [STAT_W-1:0] ST_SHUTDOWN    = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 1'd1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] pop_data;
    logic [FILL_W-1:0] fill_count;
    logic              is_full;
    logic              is_empty;
    logic [CTR_W-1:0]  enqueued_total;
    logic [CTR_W-1:0]  dropped_total;
    logic [CTR_W-1:0]  blocked_total;
  } fwop_result_t;

endpackage

@@ hdl/fwop_core.sv @@
// ----------------------------------------------------------------------------
// fwop_core
// Queue storage, pointers, event counters and the per-request policy decision.
// One request is resolved combinationally and the state updated when step is high.
// ----------------------------------------------------------------------------
module fwop_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [fwop_pkg::CMD_W-1:0]          cmd,
  input  logic [fwop_pkg::DATA_W-1:0]         push_data,
  input  logic [fwop_pkg::CAP_W-1:0]          cap_cfg,
  input  logic [fwop_pkg::POL_W-1:0]          policy,
  output fwop_pkg::fwop_result_t              result
);
  import fwop_pkg::*;

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int SUM_W = CNT_W + 1;

  logic [WORD_BITS-1:0] store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 shut_r, shut_nxt;
  logic [CTR_W-1:0]     enq_r, enq_nxt;
  logic [CTR_W-1:0]     drop_r, drop_nxt;
  logic [CTR_W-1:0]     blk_r, blk_nxt;

  logic [CMP_W-1:0]     cap_ext, cap;
  logic                 full_now;
  logic [SUM_W-1:0]     slot_sum;
  logic [PTR_W-1:0]     slot;
  logic [PTR_W-1:0]     head_inc;
  logic                 wr_en;
  logic [STAT_W-1:0]    status;
  logic [WORD_BITS-1:0] popped;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    return (&v) ? v : v + CTR_W'(1);
  endfunction

  always_comb begin
    cap_ext = CMP_W'(cap_cfg);
    if (cap_ext == '0) begin
      cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(QUEUE_DEPTH)) begin
      cap = CMP_W'(QUEUE_DEPTH);
    end else begin
      cap = cap_ext;
    end
  end

  assign full_now = CMP_W'(count_r) >= cap;
  assign slot_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign slot     = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    PTR_W'(slot_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(slot_sum);
  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    shut_nxt  = shut_r;
    enq_nxt   = enq_r;
    drop_nxt  = drop_r;
    blk_nxt   = blk_r;
    wr_en     = 1'b0;
    popped    = '0;
    status    = ST_ACCEPTED;
    if (cmd[1]) begin
      shut_nxt = 1'b1;
      status   = ST_SHUTDOWN;
    end else if (cmd == CMD_POP) begin
      if (count_r == '0) begin
        status = ST_EMPTY;
      end else begin
        popped    = store_r[head_r];
        head_nxt  = head_inc;
        count_nxt = count_r - CNT_W'(1);
        status    = ST_POPPED;
      end
    end else if (!full_now) begin
      wr_en     = 1'b1;
      count_nxt = count_r + CNT_W'(1);
      enq_nxt   = sat_inc(enq_r);
      status    = ST_ACCEPTED;
    end else if (policy == POL_DROP_OLD) begin
      wr_en    = 1'b1;
      head_nxt = head_inc;
      drop_nxt = sat_inc(drop_r);
      enq_nxt  = sat_inc(enq_r);
      status   = ST_OLD_DROPPED;
    end else if (policy == POL_BLOCK) begin
      if (shut_r) begin
        status = ST_REFUSED;
      end else begin
        blk_nxt = sat_inc(blk_r);
        status  = ST_RETRY;
      end
    end else begin
      drop_nxt = sat_inc(drop_r);
      status   = ST_NEW_DROPPED;
    end
  end

  always_comb begin
    result.status         = status;
    result.pop_data       = DATA_W'(popped);
    result.fill_count     = FILL_W'(count_nxt);
    result.is_full        = CMP_W'(count_nxt) >= cap;
    result.is_empty       = count_nxt == '0;
    result.enqueued_total = enq_nxt;
    result.dropped_total  = drop_nxt;
    result.blocked_total  = blk_nxt;
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      store_r[slot] <= push_data[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      shut_r  <= 1'b0;
      enq_r   <= '0;
      drop_r  <= '0;
      blk_r   <= '0;
    end else if (step) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      shut_r  <= shut_nxt;
      enq_r   <= enq_nxt;
      drop_r  <= drop_nxt;
      blk_r   <= blk_nxt;
    end
  end

endmodule

@@ hdl/fifo_with_overflow_policy.sv @@
// ----------------------------------------------------------------------------
// fifo_with_overflow_policy
// Bounded FIFO of data words with a configurable capacity and overflow policy.
// ----------------------------------------------------------------------------
// Each request on the input stream (push, pop or shutdown, selected by
// in_tuser) produces exactly one result on the output stream, in order. The
// block takes one request per clock cycle while the result register is free
// or its result is taken. An accepted request is held in the input register;
// when it advances, the queue pointers, fill count and counters are updated
// and the result is loaded into the result register, from which it is
// offered on the output. A full output register only stalls the input when
// the result is not taken. Capacity and policy are written through the cfg
// port; the user must write them only while no request is in flight, as the
// block itself does not enforce this; capacity 0 acts as 1.
module fifo_with_overflow_policy (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // push_data
  input  logic [fwop_pkg::DATA_W-1:0]         in_tdata,
  // cmd
  input  logic [fwop_pkg::CMD_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // pop_data, fill_count, is_full, is_empty, enqueued_total, dropped_total,
  // blocked_total, zero pad
  output logic [fwop_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status
  output logic [fwop_pkg::STAT_W-1:0]         out_tuser,
  input  logic                                cfg_we,
  input  logic [fwop_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fwop_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fwop_pkg::*;

  logic [CAP_W-1:0]  cap_r;
  logic [POL_W-1:0]  pol_r;
  logic              in_valid_r;
  logic [CMD_W-1:0]  in_cmd_r;
  logic [DATA_W-1:0] in_data_r;
  logic              out_valid_r;
  fwop_result_t      out_res_r;
  fwop_result_t      result;
  logic              adv;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      pol_r <= POL_DROP_NEW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: cap_r <= cfg_wdata[CAP_W-1:0];
        CFG_POLICY:   pol_r <= cfg_wdata[POL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r  <= in_tuser;
      in_data_r <= in_tdata;
    end
  end

  fwop_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .cmd       (in_cmd_r),
    .push_data (in_data_r),
    .cap_cfg   (cap_r),
    .policy    (pol_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.blocked_total,
                                    out_res_r.dropped_total,
                                    out_res_r.enqueued_total,
                                    out_res_r.is_empty,
                                    out_res_r.is_full,
                                    out_res_r.fill_count,
                                    out_res_r.pop_data});

endmodule
